// ===== sv/value_noise_fbm_assert.svh =====
// Assertion macros used by the value noise normalizer.
`ifndef VALUE_NOISE_FBM_ASSERT_SVH
`define VALUE_NOISE_FBM_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define VNF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define VNF_ASSERT_NORST(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define VNF_ASSERT(lbl, clk, rst, prop)
`define VNF_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// ===== sv/vnf_pkg.sv =====
// Package with the constants and types of the value noise block.
`default_nettype none
package vnf_pkg;
   localparam int MAX_OCTAVES = 8;
   localparam int OCT_W       = $clog2(MAX_OCTAVES + 1);
   localparam int SUM_W       = 16 + MAX_OCTAVES;
   localparam int DIV_W       = MAX_OCTAVES;
   localparam int CELL_DEPTH  = 11;
   localparam int W_DEPTH     = 8;

   localparam logic [OCT_W-1:0] OCT_RESET = OCT_W'(3);

   localparam logic [31:0] HASH_MUL_X = 32'h27d4eb2d;
   localparam logic [31:0] HASH_MUL_Z = 32'h165667b1;
   localparam logic [31:0] HASH_MUL_H = 32'h9e3779b1;

   localparam logic [16:0] MOD_BASE    = 17'd100000;
   localparam logic [15:0] MOD_RECIP   = 16'd42949;
   localparam logic [11:0] FRAC_DIV    = 12'd3125;
   localparam logic [16:0] FRAC_RECIP  = 17'd85899;
   localparam int          FRAC_SHIFT  = 28;

   localparam logic [32:0] NORM_RECIP [0:8] = '{
      33'd4294967296, 33'd4294967296, 33'd1431655765, 33'd613566756, 33'd286331153,
      33'd138547332, 33'd68174084, 33'd33818640, 33'd16843009
   };

   typedef struct packed {
      logic             valid;
      logic [OCT_W-1:0] octaves;
      logic [OCT_W-1:0] remain;
      logic [31:0]      x;
      logic [31:0]      z;
      logic [SUM_W-1:0] sum;
   } cell_data_type;
endpackage
`default_nettype wire

// ===== sv/vnf_hash.sv =====
// Pipelined lattice hash that maps a corner index pair to a Q0.16 value.
`default_nettype none
module vnf_hash (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [31:0] xi,
   input  wire logic [31:0] zi,
   output logic      [15:0] value
);
   import vnf_pkg::*;

   logic [31:0] px_ff, pz_ff, h3_ff, h4_ff, h5_ff, h5b_ff, p_ff;
   logic [47:0] m_ff;
   logic [16:0] r_ff;
   logic [27:0] t_ff, t2_ff;
   logic [44:0] m2_ff;
   logic [15:0] v0_ff, v_ff;
   logic [27:0] p2_ff;
   logic [31:0] h1, h2, h3_in, h5_in, r_raw;
   logic [15:0] q0, v0_in;
   logic [27:0] rem2;

   always_comb begin
      h1    = px_ff ^ (px_ff >> 15);
      h2    = h1 + pz_ff;
      h3_in = h2 ^ (h2 >> 13);
      h5_in = h4_ff ^ (h4_ff >> 16);
      q0    = m_ff[47:32];
      r_raw = h5b_ff - p_ff;
      v0_in = m2_ff[43:28];
      rem2  = t2_ff - p2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff  <= xi * HASH_MUL_X;
         pz_ff  <= zi * HASH_MUL_Z;
         h3_ff  <= h3_in;
         h4_ff  <= h3_ff * HASH_MUL_H;
         h5_ff  <= h5_in;
         m_ff   <= 48'(h5_in) * 48'(MOD_RECIP);
         h5b_ff <= h5_ff;
         p_ff   <= 32'(32'(q0) * 32'(MOD_BASE));
         r_ff   <= (r_raw >= 32'(MOD_BASE)) ? 17'(r_raw - 32'(MOD_BASE)) : r_raw[16:0];
         t_ff   <= {r_ff, 11'b0};
         m2_ff  <= 45'({r_ff, 11'b0}) * 45'(FRAC_RECIP);
         t2_ff  <= t_ff;
         v0_ff  <= v0_in;
         p2_ff  <= 28'(v0_in) * 28'(FRAC_DIV);
         v_ff   <= (rem2 >= 28'(FRAC_DIV)) ? v0_ff + 16'd1 : v0_ff;
      end
   end

   assign value = v_ff;
endmodule
`default_nettype wire

// ===== sv/vnf_cell.sv =====
// One octave cell: noise of one octave, folded into the running weighted sum while octaves remain.
`default_nettype none
module vnf_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire vnf_pkg::cell_data_type cell_in,
   output vnf_pkg::cell_data_type      cell_out
);
   import vnf_pkg::*;

   cell_data_type pipe_ff [CELL_DEPTH];
   cell_data_type out_ff, out_in;
   logic [31:0] x0, x1, z0, z1, f2x_ff, f2z_ff;
   logic [17:0] tx_ff, tz_ff;
   logic [49:0] wxp, wzp;
   logic [15:0] wx_ff [W_DEPTH];
   logic [15:0] wz_ff [W_DEPTH];
   logic [15:0] wz9_ff, ab_ff, cd_ff, noise_ff;
   logic [15:0] va, vb, vc, vd;
   logic [33:0] ab_s, cd_s, n_s;

   assign x0 = {{16{cell_in.x[31]}}, cell_in.x[31:16]};
   assign z0 = {{16{cell_in.z[31]}}, cell_in.z[31:16]};
   assign x1 = x0 + 32'd1;
   assign z1 = z0 + 32'd1;

   vnf_hash u_hash_a (.clock(clock), .en(en), .xi(x0), .zi(z0), .value(va));
   vnf_hash u_hash_b (.clock(clock), .en(en), .xi(x1), .zi(z0), .value(vb));
   vnf_hash u_hash_c (.clock(clock), .en(en), .xi(x0), .zi(z1), .value(vc));
   vnf_hash u_hash_d (.clock(clock), .en(en), .xi(x1), .zi(z1), .value(vd));

   always_comb begin
      wxp  = 50'(f2x_ff) * 50'(tx_ff);
      wzp  = 50'(f2z_ff) * 50'(tz_ff);
      ab_s = 34'(va) * 34'(17'h10000 - 17'(wx_ff[W_DEPTH-1]))
           + 34'(vb) * 34'(wx_ff[W_DEPTH-1]);
      cd_s = 34'(vc) * 34'(17'h10000 - 17'(wx_ff[W_DEPTH-1]))
           + 34'(vd) * 34'(wx_ff[W_DEPTH-1]);
      n_s  = 34'(ab_ff) * 34'(17'h10000 - 17'(wz9_ff)) + 34'(cd_ff) * 34'(wz9_ff);
   end

   always_comb begin
      out_in       = pipe_ff[CELL_DEPTH-1];
      out_in.x     = pipe_ff[CELL_DEPTH-1].x << 1;
      out_in.z     = pipe_ff[CELL_DEPTH-1].z << 1;
      if (pipe_ff[CELL_DEPTH-1].remain != '0) begin
         out_in.remain = pipe_ff[CELL_DEPTH-1].remain - OCT_W'(1);
         out_in.sum    = SUM_W'(pipe_ff[CELL_DEPTH-1].sum << 1) + SUM_W'(noise_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f2x_ff   <= 32'(cell_in.x[15:0]) * 32'(cell_in.x[15:0]);
         f2z_ff   <= 32'(cell_in.z[15:0]) * 32'(cell_in.z[15:0]);
         tx_ff    <= 18'h30000 - {1'b0, cell_in.x[15:0], 1'b0};
         tz_ff    <= 18'h30000 - {1'b0, cell_in.z[15:0], 1'b0};
         wx_ff[0] <= wxp[47:32];
         wz_ff[0] <= wzp[47:32];
         for (int k = 1; k < W_DEPTH; k++) begin
            wx_ff[k] <= wx_ff[k-1];
            wz_ff[k] <= wz_ff[k-1];
         end
         wz9_ff   <= wz_ff[W_DEPTH-1];
         ab_ff    <= ab_s[31:16];
         cd_ff    <= cd_s[31:16];
         noise_ff <= n_s[31:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CELL_DEPTH; k++) begin
            pipe_ff[k].valid <= 1'b0;
         end
         out_ff.valid <= 1'b0;
      end else if (en) begin
         pipe_ff[0] <= cell_in;
         for (int k = 1; k < CELL_DEPTH; k++) begin
            pipe_ff[k] <= pipe_ff[k-1];
         end
         out_ff <= out_in;
      end
   end

   assign cell_out = out_ff;
endmodule
`default_nettype wire

// ===== sv/vnf_norm.sv =====
// Divides the weighted octave sum by the weight total and registers the result.
`default_nettype none
`include "value_noise_fbm_assert.svh"
module vnf_norm (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire vnf_pkg::cell_data_type sum_in,
   output logic                        rsp_valid,
   output logic [15:0]                 rsp_noise_value
);
   import vnf_pkg::*;

   logic             a_valid_ff, b_valid_ff, rsp_valid_ff;
   logic [SUM_W-1:0] a_sum_ff, b_sum_ff, b_q_ff, b_p_ff, q0, rem;
   logic [DIV_W-1:0] a_d_ff, b_d_ff, d_in;
   logic [DIV_W:0]   d_full;
   logic [56:0]      a_m_ff;
   logic [15:0]      rsp_value_ff;

   assign d_full = (DIV_W + 1)'(1) << sum_in.octaves;
   assign d_in   = DIV_W'(d_full - (DIV_W + 1)'(1));
   assign q0     = a_m_ff[32 +: SUM_W];
   assign rem    = b_sum_ff - b_p_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a_sum_ff     <= sum_in.sum;
         a_d_ff       <= d_in;
         a_m_ff       <= 57'(sum_in.sum) * 57'(NORM_RECIP[sum_in.octaves]);
         b_sum_ff     <= a_sum_ff;
         b_d_ff       <= a_d_ff;
         b_q_ff       <= q0;
         b_p_ff       <= SUM_W'(q0 * SUM_W'(a_d_ff));
         rsp_value_ff <= (rem >= SUM_W'(b_d_ff)) ? 16'(b_q_ff + SUM_W'(1)) : b_q_ff[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff   <= sum_in.valid;
         b_valid_ff   <= a_valid_ff;
         rsp_valid_ff <= b_valid_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_value_ff;

   `VNF_ASSERT(a_quotient_low, clock, reset, b_valid_ff |-> b_p_ff <= b_sum_ff)
   `VNF_ASSERT(a_one_correction, clock, reset, b_valid_ff |-> rem < SUM_W'({b_d_ff, 1'b0}))
   `VNF_ASSERT(a_word_moves, clock, reset, (b_valid_ff && en) |=> rsp_valid_ff)
   `VNF_ASSERT_NORST(a_reset_empty, clock, reset |=> !rsp_valid_ff)
endmodule
`default_nettype wire

// ===== sv/value_noise_fbm.sv =====
// Top level of the fractal value noise block: a chain of octave cells.
// The req channel takes one word per cycle while req_stall is low, a Q16.16 x and z sample point.
// The rsp channel returns one Q0.16 noise word per request, in request order.
// Both channels use valid and stall; a word moves when valid is high and
// stall is low. The csr port writes the octave count with csr_write_enable.
// A count of zero acts as one octave and counts above eight act as eight.
// Every word passes through eight octave cells of twelve stages each and a
// three stage normalizer.
// Throughput is one word per cycle while the chain is not stalled, whatever the octave count.
// A stalled result holds the whole chain, and req_stall rises in that cycle.
// Reset empties the chain and sets the octave count to three.
`default_nettype none
module value_noise_fbm (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_x_coord,
   input  wire logic [31:0] req_z_coord,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_noise_value,
   input  wire logic        csr_write_enable,
   input  wire logic [3:0]  csr_write_data
);
   import vnf_pkg::*;

   logic [OCT_W-1:0] octave_count_ff, n_clamped;
   logic             en;
   cell_data_type    chain [MAX_OCTAVES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         octave_count_ff <= OCT_RESET;
      end else if (csr_write_enable) begin
         octave_count_ff <= OCT_W'(csr_write_data);
      end
   end

   always_comb begin
      priority if (octave_count_ff == '0) begin
         n_clamped = OCT_W'(1);
      end else if (octave_count_ff > OCT_W'(MAX_OCTAVES)) begin
         n_clamped = OCT_W'(MAX_OCTAVES);
      end else begin
         n_clamped = octave_count_ff;
      end
   end

   assign req_stall = rsp_valid && rsp_stall;
   assign en        = !req_stall;

   always_comb begin
      chain[0].valid   = req_valid;
      chain[0].octaves = n_clamped;
      chain[0].remain  = n_clamped;
      chain[0].x       = req_x_coord;
      chain[0].z       = req_z_coord;
      chain[0].sum     = '0;
   end

   for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_cell
      vnf_cell u_cell (
         .clock(clock), .reset(reset), .en(en),
         .cell_in(chain[g]), .cell_out(chain[g+1])
      );
   end

   vnf_norm u_norm (
      .clock(clock), .reset(reset), .en(en), .sum_in(chain[MAX_OCTAVES]),
      .rsp_valid(rsp_valid), .rsp_noise_value(rsp_noise_value)
   );
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the fractal value noise block.
`default_nettype none
class noise_scoreboard;
   logic [15:0] pending[$];
   logic [3:0]  octaves;
   int          errors;

   function new();
      octaves = 4'd3;
      errors = 0;
   endfunction

   function logic [31:0] corner_value(logic [31:0] xi, logic [31:0] zi);
      logic [31:0] h;
      logic [63:0] r;
      h = xi * 32'h27d4eb2d;
      h = h ^ (h >> 15);
      h = h + zi * 32'h165667b1;
      h = h ^ (h >> 13);
      h = h * 32'h9e3779b1;
      h = h ^ (h >> 16);
      r = 64'(h % 32'd100000);
      return 32'(((r << 16) / 64'd100000));
   endfunction

   function logic [31:0] fade(logic [31:0] f);
      logic [63:0] f2;
      logic [63:0] t;
      f2 = 64'(f) * 64'(f);
      t = 64'(32'd3 << 16) - 64'(2) * 64'(f);
      return 32'((f2 * t) >> 32);
   endfunction

   function logic [31:0] mix(logic [31:0] a, logic [31:0] b, logic [31:0] w);
      logic [63:0] s;
      s = 64'(a) * 64'(32'd65536 - w) + 64'(b) * 64'(w);
      return 32'(s >> 16);
   endfunction

   function logic [31:0] octave_value(logic [31:0] xs, logic [31:0] zs);
      logic [31:0] x0, z0, wx, wz, ab, cd;
      x0 = {{16{xs[31]}}, xs[31:16]};
      z0 = {{16{zs[31]}}, zs[31:16]};
      wx = fade({16'd0, xs[15:0]});
      wz = fade({16'd0, zs[15:0]});
      ab = mix(corner_value(x0, z0), corner_value(x0 + 1, z0), wx);
      cd = mix(corner_value(x0, z0 + 1), corner_value(x0 + 1, z0 + 1), wx);
      return mix(ab, cd, wz);
   endfunction

   function void note_request(logic [31:0] x, logic [31:0] z);
      int n;
      logic [63:0] total;
      n = octaves;
      if (n == 0) n = 1;
      if (n > 8) n = 8;
      total = 0;
      for (int i = 0; i < n; i++)
         total += 64'(octave_value(x << i, z << i)) << (n - 1 - i);
      pending.push_back(16'(total / ((64'd1 << n) - 1)));
   endfunction

   task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
   endtask

   task check_response(logic [15:0] got);
      logic [15:0] want;
      if (pending.size() == 0) begin
         report($sformatf("unexpected noise word %h", got));
      end else begin
         want = pending.pop_front();
         if (got !== want)
            report($sformatf("noise_value got %h expected %h", got, want));
      end
   endtask
endclass

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall, rsp_valid, rsp_stall = 0;
   logic [31:0] req_x_coord = 0, req_z_coord = 0;
   logic [15:0] rsp_noise_value;
   logic csr_write_enable = 0;
   logic [3:0] csr_write_data = 0;
   noise_scoreboard board = new();
   int idle_cycles = 0;
   int stall_left = 0;
   bit draining = 0;

   value_noise_fbm uut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_response(rsp_noise_value);
      end
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset || draining) begin
         stall_left = 0;
      end else if (rsp_valid && !rsp_stall) begin
         stall_left = $urandom_range(0, 10);
         if ($urandom_range(0, 3) == 0) stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
      end
      rsp_stall <= (stall_left != 0);
   end

   task automatic send_sample(logic [31:0] x, logic [31:0] z);
      int gap;
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_x_coord <= x;
      req_z_coord <= z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(x, z);
   endtask

   task automatic wait_empty();
      req_valid <= 0;
      draining = 1;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (110) @(posedge clock);
      draining = 0;
   endtask

   task automatic write_octaves(logic [3:0] n);
      csr_write_enable <= 1;
      csr_write_data <= n;
      @(posedge clock);
      csr_write_enable <= 0;
      board.octaves = n;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
         2: return {$urandom_range(0, 1) ? 16'h7fff : 16'h8000, 16'($urandom)};
         default: return {16'($urandom_range(0, 40) - 20), 16'($urandom)};
      endcase
   endfunction

   initial begin
      logic [3:0] modes[6];
      modes = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd5, 4'd2};
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_sample(32'h0, 32'h0);
      send_sample(32'h7fffffff, 32'h80000000);
      send_sample(32'h80000000, 32'h7fffffff);
      send_sample(32'hffffffff, 32'hffffffff);
      send_sample(32'h0000ffff, 32'hffff0000);
      send_sample(32'h00008000, 32'h00018000);
      send_sample(32'hfffe8000, 32'h40000000);
      wait_empty();
      foreach (modes[m]) begin
         write_octaves(modes[m]);
         send_sample(32'h7fffffff, 32'h7fffffff);
         send_sample(32'h80000000, 32'h80000000);
         send_sample(32'hffff0001, 32'h0000ffff);
         for (int k = 0; k < 300; k++) send_sample(rand_coord(), rand_coord());
         wait_empty();
      end
      write_octaves(4'd3);
      for (int k = 0; k < 100; k++) send_sample(rand_coord(), rand_coord());
      wait_empty();
      if (board.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/vnf_pkg.sv
sv/vnf_hash.sv
sv/vnf_cell.sv
sv/vnf_norm.sv
sv/value_noise_fbm.sv
tb/sv/tb.sv
